FILE: sv/swb_pkg.sv
// ----------------------------------------------------------------------------
// swb_pkg
// shared types and constants of the swept box collision pipeline
// ----------------------------------------------------------------------------
package swb_pkg;

    localparam int DIV_STAGES  = 33;   // one quotient bit per stage, Q0.32 plus integer bit
    localparam int SQRT_STAGES = 32;   // one root bit per stage, 64 bit radicand

    // one edge test on its way through the divider
    typedef struct packed {
        logic               en;      // edge tested and crossing inside the motion segment
        logic [31:0]        a;       // distance to the edge line along the motion axis
        logic [31:0]        s;       // speed on the motion axis
        logic               cneg;    // cross axis velocity is negative
        logic [31:0]        cmag;    // cross axis velocity magnitude
        logic signed [33:0] cc;      // center on the cross axis
        logic signed [33:0] lo;      // edge ends
        logic signed [33:0] hi;
        logic signed [33:0] fixed;   // edge line coordinate
    } t_lane;

    // result fields that ride along with the root
    typedef struct packed {
        logic        hit;
        logic [31:0] px;
        logic [31:0] py;
    } t_side;

endpackage

FILE: sv/swb_div.sv
// ----------------------------------------------------------------------------
// swb_div
// pipelined restoring divider: t = floor(a * 2^32 / s) for a <= s
// ----------------------------------------------------------------------------
module swb_div import swb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_ce,
    input  t_lane       i_lane,
    output t_lane       o_lane,
    output logic [32:0] o_quo
);

    typedef struct packed {
        t_lane       l;
        logic [32:0] rem;
        logic [32:0] q;
    } t_div_st;

    t_div_st r_st [DIV_STAGES];
    t_div_st n_st [DIV_STAGES];

    always_comb begin
        t_div_st     prev;
        logic [32:0] r;
        logic        ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                prev.l   = i_lane;
                prev.rem = {1'b0, i_lane.a};
                prev.q   = '0;
                r        = prev.rem;
            end else begin
                prev = r_st[k-1];
                r    = {prev.rem[31:0], 1'b0};
            end
            ge          = (r >= {1'b0, prev.l.s});
            n_st[k].l   = prev.l;
            n_st[k].rem = ge ? (r - {1'b0, prev.l.s}) : r;
            n_st[k].q   = {prev.q[31:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st <= n_st;
        end
    end

    assign o_lane = r_st[DIV_STAGES-1].l;
    assign o_quo  = r_st[DIV_STAGES-1].q;

endmodule

FILE: sv/swb_isqrt.sv
// ----------------------------------------------------------------------------
// swb_isqrt
// pipelined integer square root of a 64 bit value, one root bit per stage
// ----------------------------------------------------------------------------
module swb_isqrt import swb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_n,
    input  t_side       i_side,
    output logic [31:0] o_root,
    output t_side       o_side
);

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] root;
        t_side       side;
    } t_sq_st;

    t_sq_st r_st [SQRT_STAGES];
    t_sq_st n_st [SQRT_STAGES];

    always_comb begin
        t_sq_st      prev;
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                prev.n    = i_n;
                prev.root = '0;
                prev.side = i_side;
            end else begin
                prev = r_st[k-1];
            end
            bitv         = 64'd1 << (62 - 2 * k);
            trial        = prev.root + bitv;
            n_st[k].side = prev.side;
            if (prev.n >= trial) begin
                n_st[k].n    = prev.n - trial;
                n_st[k].root = (prev.root >> 1) + bitv;
            end else begin
                n_st[k].n    = prev.n;
                n_st[k].root = prev.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st <= n_st;
        end
    end

    assign o_root = r_st[SQRT_STAGES-1].root[31:0];
    assign o_side = r_st[SQRT_STAGES-1].side;

endmodule

FILE: sv/swept_box_collision.sv
// ----------------------------------------------------------------------------
// swept_box_collision
// swept box against fixed box query: nearest edge impact and its distance
// ----------------------------------------------------------------------------
// Input stream s_axis carries one query per request: mover box, velocity and
// obstacle box, all Q16.16. Output stream m_axis returns exactly one result
// per query in order: tuser is the hit flag, tdata holds impact x, impact y
// and the distance (all zero when nothing is hit).
// A new query may enter in every cycle while s_axis_tready is high: the
// pipeline is 2 setup stages, a 33 stage divider (one quotient bit each), 4
// stages for product, squares and the nearest choice, a 32 stage square root
// (one root bit each) and the output register.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
module swept_box_collision import swb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mover_x, mover_y, mover_w, mover_h, vel_x, vel_y,
    // obstacle_x, obstacle_y, obstacle_w, obstacle_h, 4 bits zero
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // impact_x, impact_y, impact_distance
    output logic [95:0]  m_axis_tdata,
    // hit
    output logic         m_axis_tuser
);

    typedef struct packed {
        logic               ok;
        logic [63:0]        a2;
        logic [63:0]        o2;
        logic signed [33:0] pos;
        logic signed [33:0] fixed;
    } t_m2;

    typedef struct packed {
        logic               ok;
        logic [63:0]        d2;
        logic signed [33:0] pos;
        logic signed [33:0] fixed;
    } t_m3;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -34'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    logic ce;
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    // input fields
    logic signed [31:0] mx, my, vx, vy, ox, oy;
    logic        [30:0] mw, mh, ow, oh;
    assign mx = s_axis_tdata[31:0];
    assign my = s_axis_tdata[63:32];
    assign mw = s_axis_tdata[94:64];
    assign mh = s_axis_tdata[125:95];
    assign vx = s_axis_tdata[157:126];
    assign vy = s_axis_tdata[189:158];
    assign ox = s_axis_tdata[221:190];
    assign oy = s_axis_tdata[253:222];
    assign ow = s_axis_tdata[284:254];
    assign oh = s_axis_tdata[315:285];

    // stage a: center and grown box
    logic               r_va;
    logic signed [33:0] r_cx, r_cy, r_l, r_b, r_r, r_t;
    logic signed [31:0] r_vx, r_vy;
    logic signed [33:0] n_cx, n_cy, n_l, n_b, n_r, n_t;

    always_comb begin
        n_cx = $signed({{2{mx[31]}}, mx}) + $signed({4'b0, mw[30:1]});
        n_cy = $signed({{2{my[31]}}, my}) + $signed({4'b0, mh[30:1]});
        n_l  = $signed({{2{ox[31]}}, ox}) - $signed({4'b0, mw[30:1]});
        n_b  = $signed({{2{oy[31]}}, oy}) - $signed({4'b0, mh[30:1]});
        n_r  = n_l + $signed({3'b0, mw}) + $signed({3'b0, ow});
        n_t  = n_b + $signed({3'b0, mh}) + $signed({3'b0, oh});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (ce) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_l  <= n_l;
            r_b  <= n_b;
            r_r  <= n_r;
            r_t  <= n_t;
            r_vx <= vx;
            r_vy <= vy;
        end
    end

    // stage b: pick the edge on each axis and check the motion segment
    logic  r_vb, r_yb;
    t_lane r_lx, r_ly;
    t_lane n_lx, n_ly;

    always_comb begin
        logic signed [35:0] ax, ay;
        logic        [31:0] sx, sy;
        ax = (r_vx > 0) ? (36'(r_l) - 36'(r_cx)) : (36'(r_cx) - 36'(r_r));
        ay = (r_vy > 0) ? (36'(r_b) - 36'(r_cy)) : (36'(r_cy) - 36'(r_t));
        sx = mag32(r_vx);
        sy = mag32(r_vy);

        n_lx.en    = (r_vx != 0) && !ax[35] && (ax <= $signed({4'b0, sx}));
        n_lx.a     = ax[31:0];
        n_lx.s     = sx;
        n_lx.cneg  = r_vy[31];
        n_lx.cmag  = sy;
        n_lx.cc    = r_cy;
        n_lx.lo    = r_b;
        n_lx.hi    = r_t;
        n_lx.fixed = (r_vx > 0) ? r_l : r_r;

        n_ly.en    = (r_vy != 0) && !ay[35] && (ay <= $signed({4'b0, sy}));
        n_ly.a     = ay[31:0];
        n_ly.s     = sy;
        n_ly.cneg  = r_vx[31];
        n_ly.cmag  = sx;
        n_ly.cc    = r_cx;
        n_ly.lo    = r_l;
        n_ly.hi    = r_r;
        n_ly.fixed = (r_vy > 0) ? r_b : r_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (ce) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // top edge is tested before the right edge
            r_yb <= r_vx[31] && r_vy[31];
            r_lx <= n_lx;
            r_ly <= n_ly;
        end
    end

    // divider stages
    t_lane       dx_lane, dy_lane;
    logic [32:0] dx_quo, dy_quo;
    logic [DIV_STAGES-1:0] r_vdiv, r_ydiv;

    swb_div u_div_x (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_lane (r_lx),
        .o_lane (dx_lane),
        .o_quo  (dx_quo)
    );

    swb_div u_div_y (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_lane (r_ly),
        .o_lane (dy_lane),
        .o_quo  (dy_quo)
    );

    // m1: cross axis offset magnitude
    logic        r_vm1, r_ym1;
    t_lane       r_m1x, r_m1y;
    logic [31:0] r_magx, r_magy;

    function automatic logic [31:0] scale(input logic [31:0] c, input logic [32:0] t);
        logic [63:0] p;
        p = 64'(c) * 64'(t[31:0]);
        return t[32] ? c : p[63:32];
    endfunction

    // m2: crossing point, interior test, squares
    logic r_vm2, r_ym2;
    t_m2  r_m2x, r_m2y;

    function automatic t_m2 m2_calc(input t_lane l, input logic [31:0] mag);
        t_m2                res;
        logic signed [33:0] off;
        off       = l.cneg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        res.pos   = l.cc + off;
        res.ok    = l.en && (l.lo < res.pos) && (res.pos < l.hi);
        res.a2    = 64'(l.a) * 64'(l.a);
        res.o2    = 64'(mag) * 64'(mag);
        res.fixed = l.fixed;
        return res;
    endfunction

    // m3: squared distance
    logic r_vm3, r_ym3;
    t_m3  r_m3x, r_m3y;

    function automatic t_m3 m3_calc(input t_m2 m);
        t_m3 res;
        res.ok    = m.ok;
        res.d2    = m.a2 + m.o2;
        res.pos   = m.pos;
        res.fixed = m.fixed;
        return res;
    endfunction

    // c: nearest choice
    logic        r_vc;
    t_side       r_side_c;
    logic [63:0] r_d2_c;
    t_side       n_side_c;
    logic [63:0] n_d2_c;

    always_comb begin
        t_m3  f, g;
        logic f_is_y, take_g, use_y;
        f_is_y = r_ym3;
        f      = f_is_y ? r_m3y : r_m3x;
        g      = f_is_y ? r_m3x : r_m3y;
        take_g = g.ok && (!f.ok || (g.d2 < f.d2));
        use_y  = take_g ? !f_is_y : f_is_y;
        n_side_c.hit = f.ok || g.ok;
        if (!(f.ok || g.ok)) begin
            n_side_c.px = '0;
            n_side_c.py = '0;
            n_d2_c      = '0;
        end else if (use_y) begin
            n_side_c.px = sat32(r_m3y.pos);
            n_side_c.py = sat32(r_m3y.fixed);
            n_d2_c      = r_m3y.d2;
        end else begin
            n_side_c.px = sat32(r_m3x.fixed);
            n_side_c.py = sat32(r_m3x.pos);
            n_d2_c      = r_m3x.d2;
        end
    end

    // square root stages
    logic [SQRT_STAGES-1:0] r_vsq;
    logic [31:0]            sq_root;
    t_side                  sq_side;

    swb_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_n    (r_d2_c),
        .i_side (r_side_c),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    // output register
    logic        r_out_v;
    logic        r_out_hit;
    logic [95:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdiv  <= '0;
            r_vm1   <= 1'b0;
            r_vm2   <= 1'b0;
            r_vm3   <= 1'b0;
            r_vc    <= 1'b0;
            r_vsq   <= '0;
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_vdiv  <= {r_vdiv[DIV_STAGES-2:0], r_vb};
            r_vm1   <= r_vdiv[DIV_STAGES-1];
            r_vm2   <= r_vm1;
            r_vm3   <= r_vm2;
            r_vc    <= r_vm3;
            r_vsq   <= {r_vsq[SQRT_STAGES-2:0], r_vc};
            r_out_v <= r_vsq[SQRT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ydiv     <= {r_ydiv[DIV_STAGES-2:0], r_yb};
            r_ym1      <= r_ydiv[DIV_STAGES-1];
            r_m1x      <= dx_lane;
            r_m1y      <= dy_lane;
            r_magx     <= scale(dx_lane.cmag, dx_quo);
            r_magy     <= scale(dy_lane.cmag, dy_quo);
            r_ym2      <= r_ym1;
            r_m2x      <= m2_calc(r_m1x, r_magx);
            r_m2y      <= m2_calc(r_m1y, r_magy);
            r_ym3      <= r_ym2;
            r_m3x      <= m3_calc(r_m2x);
            r_m3y      <= m3_calc(r_m2y);
            r_side_c   <= n_side_c;
            r_d2_c     <= n_d2_c;
            r_out_hit  <= sq_side.hit;
            r_out_data <= {sq_root, sq_side.py, sq_side.px};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = r_out_data;

    // a miss carries all zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss result with nonzero payload");

    a_miss_d2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc && !r_side_c.hit |-> r_d2_c == '0)
        else $error("miss with nonzero squared distance");

    // a frozen pipeline keeps its output data and the choice stage valid bit
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r_out_data) && $stable(r_vc))
        else $error("pipeline moved while stalled");

endmodule
